// ===== hw/rtl/ket_pkg.sv =====
// ket_pkg: shared types and constants of the keyed entry table
`timescale 1ns / 1ps

package ket_pkg;

  // table geometry
  localparam int TableEntries = 16;
  localparam int IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  // field widths
  localparam int IdW    = 32;
  localparam int CountW = 8;
  localparam int StampW = 32;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_CLEAR  = 2'd3
  } ket_action_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_UPDATED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_FOUND    = 3'd5
  } ket_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_EXEC,
    S_RESP
  } ket_state_e;

  // one stored slot, valid bit kept apart in flops
  typedef struct packed {
    logic [IdW-1:0]    id;
    logic [CountW-1:0] cur;
    logic [CountW-1:0] max;
    logic [StampW-1:0] stamp;
  } ket_slot_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic exec;
  } ket_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
  } ket_sts_t;

endpackage

// ===== hw/rtl/ket_req_if.sv =====
// ket_req_if: request channel of the keyed entry table
`timescale 1ns / 1ps

interface ket_req_if;
  import ket_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [IdW-1:0]      entry_id;
  logic [CountW-1:0]   current_count;
  logic [CountW-1:0]   max_count;
  logic [StampW-1:0]   time_stamp;

  modport source (
    output valid, action, entry_id, current_count, max_count, time_stamp,
    input  ready
  );

  modport sink (
    input  valid, action, entry_id, current_count, max_count, time_stamp,
    output ready
  );
endinterface

// ===== hw/rtl/ket_rsp_if.sv =====
// ket_rsp_if: result channel of the keyed entry table
`timescale 1ns / 1ps

interface ket_rsp_if;
  import ket_pkg::*;

  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic [CountW-1:0]   stored_current;
  logic [CountW-1:0]   stored_max;
  logic [StampW-1:0]   stored_time;
  logic                table_full;

  modport source (
    output valid, status, stored_current, stored_max, stored_time, table_full,
    input  ready
  );

  modport sink (
    input  valid, status, stored_current, stored_max, stored_time, table_full,
    output ready
  );
endinterface

// ===== hw/rtl/keyed_entry_table.sv =====
// keyed_entry_table: top level of the keyed entry table
// steps: S_IDLE captures a request beat, S_SCAN reads one slot per cycle through the
//   slot memory read port, S_WAIT ends the last compare, S_EXEC runs the action and
//   S_RESP holds the result beat until it is taken
// one item in flight; a new request beat is taken only after the result beat
// reset: asynchronous, active low; every slot is freed at once, slot data is not cleared
`timescale 1ns / 1ps

module keyed_entry_table
  import ket_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  ket_req_if.sink  req_i,
  ket_rsp_if.source rsp_o
);

  ket_cmd_t cmd;
  ket_sts_t sts;

  // controller
  ket_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath
  ket_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (req_i.action),
    .entry_id_i       (req_i.entry_id),
    .current_count_i  (req_i.current_count),
    .max_count_i      (req_i.max_count),
    .time_stamp_i     (req_i.time_stamp),
    .status_o         (rsp_o.status),
    .stored_current_o (rsp_o.stored_current),
    .stored_max_o     (rsp_o.stored_max),
    .stored_time_o    (rsp_o.stored_time),
    .table_full_o     (rsp_o.table_full)
  );

endmodule

// ===== hw/rtl/ket_ctrl.sv =====
// ket_ctrl: sequencing state machine of the keyed entry table
`timescale 1ns / 1ps

module ket_ctrl
  import ket_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  ket_sts_t sts_i,
  output ket_cmd_t cmd_o
);

  ket_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.scan_last) state_d = S_WAIT;
      end
      S_WAIT: state_d = S_EXEC;
      S_EXEC: state_d = S_RESP;
      S_RESP: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o           = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      S_SCAN: cmd_o.scan_step = 1'b1;
      S_WAIT: ;
      S_EXEC: cmd_o.exec = 1'b1;
      S_RESP: out_valid_o = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/ket_dpath.sv =====
// ket_dpath: slot storage, scan compare and result registers
`timescale 1ns / 1ps

module ket_dpath
  import ket_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ket_cmd_t          cmd_i,
  output ket_sts_t          sts_o,
  input  logic [1:0]        action_i,
  input  logic [IdW-1:0]    entry_id_i,
  input  logic [CountW-1:0] current_count_i,
  input  logic [CountW-1:0] max_count_i,
  input  logic [StampW-1:0] time_stamp_i,
  output logic [2:0]        status_o,
  output logic [CountW-1:0] stored_current_o,
  output logic [CountW-1:0] stored_max_o,
  output logic [StampW-1:0] stored_time_o,
  output logic              table_full_o
);

  // request registers
  ket_action_e act_q;
  ket_slot_t   req_q;

  // slot storage
  ket_slot_t              mem_q [TableEntries];
  logic [TableEntries-1:0] valid_q, valid_d;
  logic                   wr_en;
  logic [IdxW-1:0]        wr_addr;

  // scan state
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] cmp_idx_q;
  logic            cmp_vld_q;
  ket_slot_t       rd_data_q;

  // scan results
  logic            hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  ket_slot_t       hit_data_q;
  logic            is_match, is_free;

  // result registers
  ket_status_e       status_q, status_d;
  logic [CountW-1:0] cur_q, cur_d, max_q, max_d;
  logic [StampW-1:0] stamp_q, stamp_d;

  // capture the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q       <= ket_action_e'(action_i);
      req_q.id    <= entry_id_i;
      req_q.cur   <= current_count_i;
      req_q.max   <= max_count_i;
      req_q.stamp <= time_stamp_i;
    end
  end

  // scan address counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_step;
      if (cmd_i.capture) begin
        idx_q <= '0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  assign sts_o.scan_last = (idx_q == IdxW'(TableEntries - 1));

  // registered slot read
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_step) begin
      rd_data_q <= mem_q[idx_q];
      cmp_idx_q <= idx_q;
    end
  end

  // slot write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= req_q;
    end
  end

  // compare stage
  assign is_match = cmp_vld_q && valid_q[cmp_idx_q] && (rd_data_q.id == req_q.id);
  assign is_free  = cmp_vld_q && !valid_q[cmp_idx_q];

  // lowest match and lowest free slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.capture) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else begin
      if (is_match && !hit_q) hit_q <= 1'b1;
      if (is_free && !free_q) free_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_match && !hit_q) begin
      hit_idx_q  <= cmp_idx_q;
      hit_data_q <= rd_data_q;
    end
    if (is_free && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // action execution
  always_comb begin
    valid_d  = valid_q;
    wr_en    = 1'b0;
    wr_addr  = hit_idx_q;
    status_d = status_q;
    cur_d    = cur_q;
    max_d    = max_q;
    stamp_d  = stamp_q;
    if (cmd_i.exec) begin
      cur_d    = '0;
      max_d    = '0;
      stamp_d  = '0;
      status_d = ST_NOTFOUND;
      case (act_q)
        ACT_ADD: begin
          if (hit_q) begin
            wr_en    = 1'b1;
            status_d = ST_UPDATED;
          end else if (free_q) begin
            wr_en             = 1'b1;
            wr_addr           = free_idx_q;
            valid_d[free_idx_q] = 1'b1;
            status_d          = ST_ADDED;
          end else begin
            status_d = ST_FULL;
          end
        end
        ACT_REMOVE: begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
            status_d           = ST_REMOVED;
          end
        end
        ACT_LOOKUP: begin
          if (hit_q) begin
            status_d = ST_FOUND;
            cur_d    = hit_data_q.cur;
            max_d    = hit_data_q.max;
            stamp_d  = hit_data_q.stamp;
          end
        end
        default: begin
          valid_d  = '0;
          status_d = ST_FOUND;
        end
      endcase
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    cur_q    <= cur_d;
    max_q    <= max_d;
    stamp_q  <= stamp_d;
  end

  assign status_o         = status_q;
  assign stored_current_o = cur_q;
  assign stored_max_o     = max_q;
  assign stored_time_o    = stamp_q;
  assign table_full_o     = &valid_q;

endmodule

// ===== hw/rtl/ket_checker.sv =====
// ket_checker: port-level assertions for the keyed entry table
`timescale 1ns / 1ps

module ket_checker
  import ket_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [2:0]        status_i,
  input logic [CountW-1:0] stored_current_i,
  input logic [CountW-1:0] stored_max_i,
  input logic [StampW-1:0] stored_time_i,
  input logic              table_full_i
);

  // a pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result beat dropped before it was taken");

  // no request beat while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("request taken while a result is pending");

  // stored fields are zero unless a lookup found its entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_FOUND) |->
      (stored_current_i == '0) && (stored_max_i == '0) && (stored_time_i == '0))
    else $error("stored fields set on a result without a found entry");

  // a rejected add means the table is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FULL) |-> table_full_i)
    else $error("full rejection while a slot is free");

endmodule

bind keyed_entry_table ket_checker u_ket_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .stored_current_i (rsp_o.stored_current),
  .stored_max_i     (rsp_o.stored_max),
  .stored_time_i    (rsp_o.stored_time),
  .table_full_i     (rsp_o.table_full)
);

// ===== verif/keyed_entry_table_checker.sv =====
// keyed_entry_table_checker: predicts every result beat of the table and checks it
`timescale 1ns / 1ps

module keyed_entry_table_checker
  import ket_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  ket_req_if   req_i,
  ket_rsp_if   rsp_i,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    ket_status_e       status;
    logic [CountW-1:0] cur;
    logic [CountW-1:0] max;
    logic [StampW-1:0] stamp;
    logic              full;
  } entry_result_t;

  // shadow copy of the slot table
  logic              slot_used  [TableEntries];
  logic [IdW-1:0]    slot_key   [TableEntries];
  logic [CountW-1:0] slot_cur   [TableEntries];
  logic [CountW-1:0] slot_max   [TableEntries];
  logic [StampW-1:0] slot_stamp [TableEntries];

  // results still owed by the block, oldest first
  entry_result_t owed_results[$];

  // lowest used slot holding key, -1 when absent
  function automatic int find_key(logic [IdW-1:0] key);
    int i;
    for (i = 0; i < TableEntries; i++) begin
      if (slot_used[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // lowest free slot, -1 when the table is full
  function automatic int find_free();
    int i;
    for (i = 0; i < TableEntries; i++) begin
      if (!slot_used[i]) return i;
    end
    return -1;
  endfunction

  // applies one request beat to the shadow table and returns its result
  function automatic entry_result_t apply_request(ket_action_e act, logic [IdW-1:0] key,
                                                  logic [CountW-1:0] cur,
                                                  logic [CountW-1:0] mx,
                                                  logic [StampW-1:0] ts);
    entry_result_t res;
    int idx;
    int i;
    res = '0;
    res.status = ST_NOTFOUND;
    case (act)
      ACT_ADD: begin
        idx = find_key(key);
        if (idx >= 0) begin
          res.status = ST_UPDATED;
        end else begin
          idx = find_free();
          res.status = (idx >= 0) ? ST_ADDED : ST_FULL;
        end
        if (idx >= 0) begin
          slot_used[idx]  = 1'b1;
          slot_key[idx]   = key;
          slot_cur[idx]   = cur;
          slot_max[idx]   = mx;
          slot_stamp[idx] = ts;
        end
      end
      ACT_REMOVE: begin
        idx = find_key(key);
        if (idx >= 0) begin
          slot_used[idx] = 1'b0;
          res.status = ST_REMOVED;
        end
      end
      ACT_LOOKUP: begin
        idx = find_key(key);
        if (idx >= 0) begin
          res.status = ST_FOUND;
          res.cur    = slot_cur[idx];
          res.max    = slot_max[idx];
          res.stamp  = slot_stamp[idx];
        end
      end
      default: begin
        for (i = 0; i < TableEntries; i++) slot_used[i] = 1'b0;
        res.status = ST_FOUND;
      end
    endcase
    res.full = (find_free() < 0);
    return res;
  endfunction

  // result beats are checked before the request beat of the same edge is predicted
  always @(posedge clk_i) begin
    entry_result_t want;
    int i;
    if (!rst_ni) begin
      for (i = 0; i < TableEntries; i++) slot_used[i] = 1'b0;
      owed_results.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (owed_results.size() == 0) begin
          if (mismatch_cnt_o < ReportLimit)
            $display("%0t: result beat with no request waiting: status %0d", $time,
                     rsp_i.status);
          mismatch_cnt_o++;
        end else begin
          want = owed_results.pop_front();
          if (rsp_i.status !== want.status || rsp_i.stored_current !== want.cur ||
              rsp_i.stored_max !== want.max || rsp_i.stored_time !== want.stamp ||
              rsp_i.table_full !== want.full) begin
            if (mismatch_cnt_o < ReportLimit) begin
              $display("%0t: result mismatch", $time);
              $display("  expected status %0d cur %0d max %0d time %h full %b",
                       want.status, want.cur, want.max, want.stamp, want.full);
              $display("  actual   status %0d cur %0d max %0d time %h full %b",
                       rsp_i.status, rsp_i.stored_current, rsp_i.stored_max,
                       rsp_i.stored_time, rsp_i.table_full);
            end
            mismatch_cnt_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        owed_results.push_back(apply_request(ket_action_e'(req_i.action), req_i.entry_id,
                                             req_i.current_count, req_i.max_count,
                                             req_i.time_stamp));
      end
    end
    pending_o = owed_results.size();
  end

endmodule

// ===== verif/keyed_entry_table_tb.sv =====
// keyed_entry_table_tb: stimulus, flow control and verdict for the keyed entry table
`timescale 1ns / 1ps

module keyed_entry_table_tb;
  import ket_pkg::*;

  localparam int ClkHalf     = 6;
  localparam int RandomItems = 1800;
  localparam int KeyPoolSize = 24;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = TableEntries + 8;

  logic clk = 1'b0;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   beats_sent;
  bit   no_gaps;
  int   hold_marks [2] = '{300, 1200};
  logic [IdW-1:0] key_pool [KeyPoolSize];

  ket_req_if req_if ();
  ket_rsp_if rsp_if ();

  keyed_entry_table DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  keyed_entry_table_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .req_i          (req_if),
    .rsp_i          (rsp_if),
    .mismatch_cnt_o (mismatches),
    .pending_o      (outstanding)
  );

  // clock
  always begin
    #ClkHalf clk = 1'b1;
    #ClkHalf clk = 1'b0;
  end

  // idle length before a request beat: mostly short, a few long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 80);
  endfunction

  // count value with extra weight on the extremes
  function automatic logic [CountW-1:0] pick_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return CountW'($urandom_range(0, 255));
  endfunction

  // offers one request beat and waits for it to be taken
  task automatic send_beat(ket_action_e act, logic [IdW-1:0] key, logic [CountW-1:0] cur,
                           logic [CountW-1:0] mx, logic [StampW-1:0] ts);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      // junk payload while idle
      req_if.valid         = 1'b0;
      req_if.action        = 2'($urandom_range(0, 3));
      req_if.entry_id      = $urandom();
      req_if.current_count = CountW'($urandom_range(0, 255));
      req_if.max_count     = CountW'($urandom_range(0, 255));
      req_if.time_stamp    = $urandom();
      repeat (gap) @(negedge clk);
    end
    req_if.valid         = 1'b1;
    req_if.action        = act;
    req_if.entry_id      = key;
    req_if.current_count = cur;
    req_if.max_count     = mx;
    req_if.time_stamp    = ts;
    do @(posedge clk); while (!req_if.ready);
    beats_sent++;
  endtask

  // result side flow control, with two long hold-offs to back up the input
  initial begin : rsp_flow
    int roll;
    int len;
    int holds;
    holds = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds < 2 && beats_sent >= hold_marks[holds]) begin
        rsp_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
        holds++;
        rsp_if.ready = 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
          rsp_if.ready = 1'b1;
          len = $urandom_range(30, 100);
        end else if (roll < 75) begin
          rsp_if.ready = 1'b1;
          len = $urandom_range(1, 4);
        end else if (roll < 95) begin
          rsp_if.ready = 1'b0;
          len = $urandom_range(1, 4);
        end else begin
          rsp_if.ready = 1'b0;
          len = $urandom_range(20, 60);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  // request stimulus and verdict
  initial begin : stimulus
    int i;
    int roll;
    ket_action_e act;
    logic [IdW-1:0] key;
    req_if.valid         = 1'b0;
    req_if.action        = ACT_ADD;
    req_if.entry_id      = '0;
    req_if.current_count = '0;
    req_if.max_count     = '0;
    req_if.time_stamp    = '0;
    no_gaps    = 1'b0;
    beats_sent = 0;
    rst_n      = 1'b0;
    key_pool[0] = '1;
    key_pool[1] = '0;
    for (i = 2; i < KeyPoolSize; i++) begin
      key_pool[i] = (i < 8) ? IdW'(i) : $urandom();
    end
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // field extremes, update, remove and lookup of present and absent keys
    send_beat(ACT_ADD, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000);
    send_beat(ACT_ADD, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_beat(ACT_LOOKUP, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'h0000_0000);
    send_beat(ACT_ADD, 32'h0000_0000, 8'h55, 8'hAA, 32'h5555_AAAA);
    send_beat(ACT_LOOKUP, 32'h0000_0000, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_beat(ACT_REMOVE, 32'h0000_0000, 8'hAA, 8'h55, 32'hAAAA_5555);
    send_beat(ACT_REMOVE, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000);
    send_beat(ACT_LOOKUP, 32'h0000_0000, 8'h00, 8'h00, 32'h0000_0000);
    // lowest free slot reused, then fill the table
    send_beat(ACT_ADD, 32'h8000_0000, 8'h01, 8'h80, 32'h8000_0001);
    for (i = 1; i < TableEntries - 1; i++) begin
      send_beat(ACT_ADD, IdW'(i), CountW'(i * 17), CountW'(255 - i), {i[3:0], 28'(i)});
    end
    // full table: new key rejected, known key still updated; then a freed slot is taken, clear and lookup
    send_beat(ACT_ADD, 32'h7FFF_FFFF, 8'h12, 8'h34, 32'h1234_5678);
    send_beat(ACT_ADD, 32'h0000_0001, 8'h9A, 8'hBC, 32'hDEAD_BEEF);
    send_beat(ACT_REMOVE, 32'hFFFF_FFFF, 8'h00, 8'h00, 32'h0000_0000);
    send_beat(ACT_ADD, 32'h7FFF_FFFF, 8'h12, 8'h34, 32'h1234_5678);
    send_beat(ACT_CLEAR, 32'h0000_0001, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    send_beat(ACT_LOOKUP, 32'h0000_0001, 8'h00, 8'h00, 32'h0000_0000);

    // random mix over a small key pool so that hits, fills and rejects are common
    for (i = 0; i < RandomItems; i++) begin
      if (i % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (i % 150 == 0) key_pool[$urandom_range(2, KeyPoolSize - 1)] = $urandom();
      roll = $urandom_range(0, 99);
      if (roll < 47)      act = ACT_ADD;
      else if (roll < 67) act = ACT_REMOVE;
      else if (roll < 97) act = ACT_LOOKUP;
      else                act = ACT_CLEAR;
      key = ($urandom_range(0, 9) == 0) ? IdW'($urandom()) :
                                          key_pool[$urandom_range(0, KeyPoolSize - 1)];
      send_beat(act, key, pick_count(), pick_count(), $urandom());
    end

    // drain
    @(negedge clk);
    req_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/ket_pkg.sv
hw/rtl/ket_req_if.sv
hw/rtl/ket_rsp_if.sv
hw/rtl/ket_ctrl.sv
hw/rtl/ket_dpath.sv
hw/rtl/keyed_entry_table.sv
hw/rtl/ket_checker.sv
verif/keyed_entry_table_checker.sv
verif/keyed_entry_table_tb.sv
